/* hw/rtl/mptg_pkg.sv */
// shared types and constants for the multichannel pulse train generator
`timescale 1ns / 1ps

package mptg_pkg;

  // channel slots in the register map and in the result fields
  localparam int NUM_LANES = 4;

  localparam int WORD_W = 32;
  localparam int FUNC_W = 3;
  localparam int CHAN_W = 3;
  localparam int ADDR_W = 5;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [FUNC_W-1:0] func_t;
  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [ADDR_W-1:0] addr_t;

  // command codes
  localparam func_t FUNC_TICK      = 3'd0;
  localparam func_t FUNC_START     = 3'd1;
  localparam func_t FUNC_STOP      = 3'd2;
  localparam func_t FUNC_START_ALL = 3'd3;
  localparam func_t FUNC_STOP_ALL  = 3'd4;

  // register reset values
  localparam word_t PERIOD_RESET = 32'd1000;
  localparam word_t LIMIT_RESET  = 32'd10;

  // per-lane command decoded from one word
  typedef struct packed {
    logic en;              // word is being processed this cycle
    logic tick;
    logic start;           // start this lane unconditionally
    logic start_if_limit;  // start this lane if its limit is nonzero
    logic stop;
  } lane_cmd_t;

endpackage

/* hw/rtl/mptg_if.sv */
// command and result channel interfaces
`timescale 1ns / 1ps

interface mptg_cmd_if;
  logic                 valid;
  logic                 ready;
  logic [2:0]           func;
  logic [2:0]           channel;

  modport source (output valid, output func, output channel, input ready);
  modport sink   (input valid, input func, input channel, output ready);
endinterface

interface mptg_res_if;
  logic                 valid;
  logic                 ready;
  logic [3:0]           pin_levels;
  logic [3:0]           running_mask;
  logic [31:0]          selected_pulse_count;

  modport source (output valid, output pin_levels, output running_mask,
                  output selected_pulse_count, input ready);
  modport sink   (input valid, input pin_levels, input running_mask,
                  input selected_pulse_count, output ready);
endinterface

/* hw/rtl/mptg_regs.sv */
// apb register file holding period and pulse limit per channel
`timescale 1ns / 1ps

module mptg_regs (
  input  logic            clk,
  input  logic            rst,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  mptg_pkg::addr_t paddr,
  input  mptg_pkg::word_t pwdata,
  output mptg_pkg::word_t prdata,
  output logic            pready,
  output mptg_pkg::word_t period [mptg_pkg::NUM_LANES],
  output mptg_pkg::word_t limit  [mptg_pkg::NUM_LANES]
);
  import mptg_pkg::*;

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  // upper half of the map is the limits, lower half the periods
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        period[i] <= PERIOD_RESET;
        limit[i]  <= LIMIT_RESET;
      end
    end else if (wr_en) begin
      if (reg_idx[2]) begin
        limit[reg_idx[1:0]] <= pwdata;
      end else begin
        period[reg_idx[1:0]] <= pwdata;
      end
    end
  end

  assign prdata = reg_idx[2] ? limit[reg_idx[1:0]] : period[reg_idx[1:0]];

endmodule

/* hw/rtl/mptg_lane.sv */
// one pulse train channel: tick counter, pulse counter, run flag and pin
`timescale 1ns / 1ps

module mptg_lane (
  input  logic                clk,
  input  logic                rst,
  input  mptg_pkg::lane_cmd_t cmd,
  input  mptg_pkg::word_t     period,
  input  mptg_pkg::word_t     limit,
  output logic                pin_next,
  output logic                run_next,
  output mptg_pkg::word_t     done_next,
  output logic                run
);
  import mptg_pkg::*;

  word_t elapsed;
  word_t elapsed_next;
  word_t done;
  logic  pin;
  word_t ticked;
  word_t done_inc;
  logic  do_start;

  assign ticked   = elapsed + 32'd1;
  assign done_inc = done + 32'd1;
  assign do_start = cmd.start || (cmd.start_if_limit && (limit != '0));

  always_comb begin
    elapsed_next = elapsed;
    done_next    = done;
    run_next     = run;
    pin_next     = pin;
    priority if (cmd.tick) begin
      if (run) begin
        pin_next = (elapsed < (period >> 1));
        if (ticked >= period) begin
          done_next    = done_inc;
          elapsed_next = '0;
          if (done_inc >= limit) begin
            run_next = 1'b0;
          end
        end else begin
          elapsed_next = ticked;
        end
      end else begin
        pin_next = 1'b0;
      end
    end else if (do_start) begin
      done_next    = '0;
      elapsed_next = '0;
      run_next     = 1'b1;
    end else if (cmd.stop) begin
      run_next = 1'b0;
    end else begin
      run_next = run;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed <= '0;
      done    <= '0;
      run     <= 1'b0;
      pin     <= 1'b0;
    end else if (cmd.en) begin
      elapsed <= elapsed_next;
      done    <= done_next;
      run     <= run_next;
      pin     <= pin_next;
    end
  end

endmodule

/* hw/rtl/multichannel_pulse_train_generator.sv */
// top level of the multichannel pulse train generator
`timescale 1ns / 1ps

// Up to four independent channels each emit a counted train of square pulses.
// Every command word (tick, start, stop, start all, stop all) yields one result
// word with the pin levels, the running flags and the pulse count of the
// addressed channel. A word is captured in an input register, processed by the
// channel update logic (one 32-bit increment and compare per counter) and
// written to the result register once that is free, so the block takes one
// word per clock; it keeps that rate while a result waits, until both the input
// and result registers are full. Periods and limits are set through the apb
// port (period i at byte 4*i, limit i at 16+4*i) while the block is idle, which
// the user must ensure as the block does not enforce it; pready is always high.

module multichannel_pulse_train_generator #(
  parameter int NUM_CHANNELS = 4
) (
  input  logic              clk,
  input  logic              rst,
  mptg_cmd_if.sink          cmd,
  mptg_res_if.source        res,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  mptg_pkg::addr_t   paddr,
  input  mptg_pkg::word_t   pwdata,
  output mptg_pkg::word_t   prdata,
  output logic              pready
);
  import mptg_pkg::*;

  localparam chan_t NumCh = CHAN_W'(NUM_CHANNELS);

  // register file
  word_t period [NUM_LANES];
  word_t limit  [NUM_LANES];

  mptg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .period  (period),
    .limit   (limit)
  );

  // input register
  logic  s1_valid;
  func_t s1_func;
  chan_t s1_channel;
  logic  s1_advance;

  // result register
  logic                 out_valid;
  logic [NUM_LANES-1:0] out_pins;
  logic [NUM_LANES-1:0] out_run;
  word_t                out_count;

  // word moves from input to result register when the result slot frees up
  assign s1_advance = s1_valid && (!out_valid || res.ready);
  assign cmd.ready  = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      if (cmd.valid && cmd.ready) begin
        s1_valid <= 1'b1;
      end else if (s1_advance) begin
        s1_valid <= 1'b0;
      end
    end
    if (cmd.valid && cmd.ready) begin
      s1_func    <= cmd.func;
      s1_channel <= cmd.channel;
    end
  end

  // channel lanes
  logic [NUM_LANES-1:0] pin_next;
  logic [NUM_LANES-1:0] run_next;
  logic [NUM_LANES-1:0] run_q;
  word_t                done_next [NUM_LANES];
  logic                 in_range;

  assign in_range = (s1_channel < NumCh);

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    if (i < NUM_CHANNELS) begin : g_on
      lane_cmd_t lcmd;
      // channel compare only matches in-range lanes, so no extra range gate
      assign lcmd.en             = s1_advance;
      assign lcmd.tick           = (s1_func == FUNC_TICK);
      assign lcmd.start          = (s1_func == FUNC_START) && (s1_channel == CHAN_W'(i));
      assign lcmd.start_if_limit = (s1_func == FUNC_START_ALL);
      assign lcmd.stop           = ((s1_func == FUNC_STOP) && (s1_channel == CHAN_W'(i)))
                                   || (s1_func == FUNC_STOP_ALL);

      mptg_lane u_lane (
        .clk       (clk),
        .rst       (rst),
        .cmd       (lcmd),
        .period    (period[i]),
        .limit     (limit[i]),
        .pin_next  (pin_next[i]),
        .run_next  (run_next[i]),
        .done_next (done_next[i]),
        .run       (run_q[i])
      );
    end else begin : g_off
      // unbuilt channel: never runs, pin low, count zero
      assign pin_next[i]  = 1'b0;
      assign run_next[i]  = 1'b0;
      assign run_q[i]     = 1'b0;
      assign done_next[i] = '0;
    end
  end

  // result register update
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (s1_advance) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
    if (s1_advance) begin
      out_pins  <= pin_next;
      out_run   <= run_next;
      // in range implies the top channel bit is clear
      out_count <= in_range ? done_next[s1_channel[1:0]] : '0;
    end
  end

  assign res.valid                = out_valid;
  assign res.pin_levels           = out_pins;
  assign res.running_mask         = out_run;
  assign res.selected_pulse_count = out_count;

  // a processed word always lands in the result register
  a_result_follows : assert property (@(posedge clk) disable iff (rst)
    s1_advance |=> res.valid)
    else $error("processed word did not produce a result");

  // channel state holds while a word waits in the input register
  a_state_holds : assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_advance) |=> $stable(run_q))
    else $error("run flags changed while the input word was stalled");

  // out-of-range query reports zero
  a_range_zero : assert property (@(posedge clk) disable iff (rst)
    (s1_advance && !in_range) |=> (res.selected_pulse_count == '0))
    else $error("out-of-range channel reported a nonzero count");

  // a start clears the pulse count of the started channel
  a_start_clears : assert property (@(posedge clk) disable iff (rst)
    (s1_advance && in_range && (s1_func == FUNC_START))
      |=> (res.selected_pulse_count == '0))
    else $error("start did not clear the pulse count");

endmodule

/* sim/testbench.sv */
// self-checking testbench for the multichannel pulse train generator
`timescale 1ns / 1ps

module testbench;
  import mptg_pkg::*;

  localparam int CHANNELS = 4;
  // register indexes in the apb map, period of lane i at i, limit of lane i at 4+i
  localparam int REG_PERIOD0 = 0;
  localparam int REG_LIMIT0  = 4;
  // cycles with nothing moving on any port before the run is declared hung
  localparam int QUIET_LIMIT = 4000;
  localparam int REPORT_MAX  = 10;

  typedef struct packed {
    func_t func;
    chan_t chan;
  } cmd_word_t;

  typedef struct packed {
    logic [3:0] pins;
    logic [3:0] running;
    word_t      count;
  } pulse_status_t;

  logic  clk;
  logic  rst;
  logic  psel;
  logic  penable;
  logic  pwrite;
  addr_t paddr;
  word_t pwdata;
  word_t prdata;
  logic  pready;

  mptg_cmd_if cmd_ch ();
  mptg_res_if res_ch ();

  multichannel_pulse_train_generator #(
    .NUM_CHANNELS(CHANNELS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .res(res_ch),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // 12 ns clock
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // ---------------------------------------------------------------------------
  // pulse train predictor: own copy of the registers and channel state
  // ---------------------------------------------------------------------------
  word_t      period_cfg [CHANNELS];
  word_t      limit_cfg  [CHANNELS];
  word_t      tick_count [CHANNELS];
  word_t      pulse_count[CHANNELS];
  logic [3:0] run_lanes;
  logic [3:0] pin_lanes;

  pulse_status_t expected_status[$];
  cmd_word_t     pending_words[$];

  int send_idle_pct;
  int recv_idle_pct;
  int error_count;
  int words_sent;
  int meaningful_words;
  int results_checked;
  int pulses_completed;
  int reg_writes;
  int quiet_cycles;

  // restart a lane from the top of its first pulse
  function automatic void restart_lane(int lane);
    pulse_count[lane] = '0;
    tick_count[lane]  = '0;
    run_lanes[lane]   = 1'b1;
  endfunction

  // apply one command word to the model and queue the status it must produce
  function automatic void predict_status(func_t f, chan_t c);
    pulse_status_t s;
    case (f)
      FUNC_TICK: begin
        for (int i = 0; i < CHANNELS; i++) begin
          if (!run_lanes[i]) begin
            pin_lanes[i] = 1'b0;
          end else begin
            // high for the first floor(period/2) ticks of each pulse
            pin_lanes[i] = tick_count[i] < (period_cfg[i] >> 1);
            tick_count[i] = tick_count[i] + 1;
            if (tick_count[i] >= period_cfg[i]) begin
              pulse_count[i] = pulse_count[i] + 1;
              pulses_completed++;
              tick_count[i] = '0;
              // the limit is only looked at here, so lowering it mid-run
              // takes effect at the end of the current pulse
              if (pulse_count[i] >= limit_cfg[i]) run_lanes[i] = 1'b0;
            end
          end
        end
      end
      // a single start runs the lane even with a zero limit
      FUNC_START: if (c < CHANNELS) restart_lane(int'(c));
      FUNC_STOP: if (c < CHANNELS) run_lanes[c[1:0]] = 1'b0;
      // start-all leaves lanes with a zero limit alone
      FUNC_START_ALL: begin
        for (int i = 0; i < CHANNELS; i++)
          if (limit_cfg[i] != '0) restart_lane(i);
      end
      FUNC_STOP_ALL: run_lanes = '0;
      default: ;  // unused codes change nothing but still answer
    endcase
    s.pins    = pin_lanes;
    s.running = run_lanes;
    s.count   = (c < CHANNELS) ? pulse_count[c[1:0]] : '0;
    expected_status.push_back(s);
  endfunction

  // ---------------------------------------------------------------------------
  // command driver: pops the pending queue, idles at random, predicts on accept
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cmd_word_t w;
    if (rst) begin
      cmd_ch.valid <= 1'b0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        predict_status(cmd_ch.func, cmd_ch.channel);
        words_sent++;
      end
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (pending_words.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          w = pending_words.pop_front();
          cmd_ch.valid   <= 1'b1;
          cmd_ch.func    <= w.func;
          cmd_ch.channel <= w.chan;
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor: random backpressure and in-order compare
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    pulse_status_t want;
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_status.size() == 0) begin
          error_count++;
          if (error_count <= REPORT_MAX)
            $display("%0t: result word with nothing expected: pins %h running %h count %0d",
                     $realtime, res_ch.pin_levels, res_ch.running_mask,
                     res_ch.selected_pulse_count);
        end else begin
          want = expected_status.pop_front();
          results_checked++;
          if (res_ch.pin_levels !== want.pins || res_ch.running_mask !== want.running ||
              res_ch.selected_pulse_count !== want.count) begin
            error_count++;
            if (error_count <= REPORT_MAX)
              $display("%0t: result %0d: expected pins %h running %h count %0d, got %h %h %0d",
                       $realtime, results_checked, want.pins, want.running, want.count,
                       res_ch.pin_levels, res_ch.running_mask,
                       res_ch.selected_pulse_count);
          end
        end
      end
      res_ch.ready <= $urandom_range(0, 99) >= recv_idle_pct;
    end
  end

  // watchdog: counts cycles in which no port moves anything
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) || psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("%0t: no progress for %0d cycles", $realtime, QUIET_LIMIT);
    $display("multichannel_pulse_train_generator: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_word(func_t f, chan_t c);
    cmd_word_t w;
    w.func = f;
    w.chan = c;
    pending_words.push_back(w);
    // words the block just ignores do not count toward the run length
    if (f == FUNC_TICK || f == FUNC_START_ALL || f == FUNC_STOP_ALL ||
        ((f == FUNC_START || f == FUNC_STOP) && c < CHANNELS))
      meaningful_words++;
  endtask

  // sender holds off until every queued word has come back as a result
  task automatic wait_idle();
    while (pending_words.size() > 0 || cmd_ch.valid || expected_status.size() > 0)
      @(posedge clk);
  endtask

  // one apb write: setup cycle, then access cycle; the register takes it on the
  // edge with psel, penable and pwrite high
  task automatic apb_write(int reg_index, word_t value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr_t'(reg_index * 4);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_index < REG_LIMIT0)
      period_cfg[reg_index] = value;
    else
      limit_cfg[reg_index - REG_LIMIT0] = value;
    reg_writes++;
  endtask

  task automatic program_lane(int lane, word_t period, word_t limit);
    apb_write(REG_PERIOD0 + lane, period);
    apb_write(REG_LIMIT0 + lane, limit);
  endtask

  // mostly short periods and limits so that pulses finish, now and then the
  // edges of the range or a full random value
  task automatic program_random_settings();
    word_t period;
    word_t limit;
    for (int lane = 0; lane < CHANNELS; lane++) begin
      case ($urandom_range(0, 9))
        0:       period = '0;
        1:       period = $urandom;
        2:       period = word_t'($urandom_range(11, 40));
        default: period = word_t'($urandom_range(1, 10));
      endcase
      case ($urandom_range(0, 9))
        0, 1:    limit = '0;
        2:       limit = $urandom;
        3:       limit = '1;
        default: limit = word_t'($urandom_range(1, 5));
      endcase
      program_lane(lane, period, limit);
    end
  endtask

  // mostly a start followed by a run of ticks, sometimes raw noise
  task automatic queue_burst();
    int run_len;
    int n;
    if ($urandom_range(0, 9) < 7) begin
      if ($urandom_range(0, 2) == 0)
        push_word(FUNC_START_ALL, chan_t'($urandom_range(0, 7)));
      else
        push_word(FUNC_START, chan_t'($urandom_range(0, CHANNELS - 1)));
      run_len = $urandom_range(1, 30);
      for (int k = 0; k < run_len; k++) begin
        case ($urandom_range(0, 24))
          0:       push_word(FUNC_STOP, chan_t'($urandom_range(0, CHANNELS - 1)));
          1:       push_word(FUNC_START, chan_t'($urandom_range(0, CHANNELS - 1)));
          2:       push_word(FUNC_STOP_ALL, chan_t'($urandom_range(0, 7)));
          default: push_word(FUNC_TICK, chan_t'($urandom_range(0, 7)));
        endcase
      end
    end else begin
      n = $urandom_range(1, 6);
      for (int k = 0; k < n; k++)
        push_word(func_t'($urandom_range(0, 7)), chan_t'($urandom_range(0, 7)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int target;
    rst            = 1'b1;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    cmd_ch.valid   = 1'b0;
    cmd_ch.func    = FUNC_TICK;
    cmd_ch.channel = '0;
    res_ch.ready   = 1'b0;
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    error_count      = 0;
    words_sent       = 0;
    meaningful_words = 0;
    results_checked  = 0;
    pulses_completed = 0;
    reg_writes       = 0;
    quiet_cycles     = 0;
    for (int i = 0; i < CHANNELS; i++) begin
      period_cfg[i]  = PERIOD_RESET;
      limit_cfg[i]   = LIMIT_RESET;
      tick_count[i]  = '0;
      pulse_count[i] = '0;
    end
    run_lanes = '0;
    pin_lanes = '0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: short period, period of one, zero period, full-scale period;
    // zero limit on lane 1, full-scale limit on lane 3
    program_lane(0, 32'd4, 32'd2);
    program_lane(1, 32'd1, 32'd0);
    program_lane(2, 32'd0, 32'd3);
    program_lane(3, '1, '1);

    push_word(FUNC_TICK, 3'd0);       // idle lanes stay low
    push_word(FUNC_START, 3'd1);      // zero limit still runs one pulse
    push_word(FUNC_START_ALL, 3'd2);  // skips the zero-limit lane
    for (int k = 0; k < 4; k++) push_word(FUNC_TICK, chan_t'(k));
    push_word(FUNC_STOP, 3'd2);       // pins hold until the next tick
    push_word(FUNC_TICK, 3'd6);
    push_word(FUNC_START, 3'd7);      // out-of-range lane index
    push_word(FUNC_STOP, 3'd5);
    push_word(func_t'(FUNC_STOP_ALL + 1), 3'd4);  // unused command codes
    push_word(func_t'(FUNC_STOP_ALL + 2), 3'd3);
    push_word(func_t'(FUNC_STOP_ALL + 3), 3'd0);
    for (int k = 0; k < 3; k++) push_word(FUNC_TICK, 3'd0);
    push_word(FUNC_STOP_ALL, 3'd3);
    push_word(FUNC_TICK, 3'd3);
    push_word(FUNC_START, 3'd0);
    push_word(FUNC_TICK, 3'd0);
    wait_idle();

    // limit dropped to zero while lane 0 is mid-pulse: it ends after this pulse
    program_lane(0, 32'd4, 32'd0);
    for (int k = 0; k < 4; k++) push_word(FUNC_TICK, 3'd0);
    wait_idle();

    // random phases: slow receiver, then slow sender, then full rate
    for (int phase = 0; phase < 6; phase++) begin
      case (phase / 2)
        0:       begin send_idle_pct = 7;  recv_idle_pct = 80; end
        1:       begin send_idle_pct = 80; recv_idle_pct = 7;  end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      program_random_settings();
      target = meaningful_words + 112;
      while (meaningful_words < target) queue_burst();
      wait_idle();
    end

    // let the last result word clear the output register
    repeat (8) @(posedge clk);

    $display("checked %0d results for %0d command words over %0d register writes",
             results_checked, words_sent, reg_writes);
    $display("lanes completed %0d pulses across all settings", pulses_completed);
    if (error_count == 0) begin
      $display("multichannel_pulse_train_generator: match");
    end else begin
      $display("%0d result words differed", error_count);
      $display("multichannel_pulse_train_generator: mismatch");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/mptg_pkg.sv
hw/rtl/mptg_if.sv
hw/rtl/mptg_regs.sv
hw/rtl/mptg_lane.sv
hw/rtl/multichannel_pulse_train_generator.sv
sim/testbench.sv
